// File: design/grid_to_earth_wind_rotation_top_defines.svh
// Assertion macros shared by the checker of the wind rotation block.
`ifndef GRID_TO_EARTH_WIND_ROTATION_TOP_DEFINES_SVH
`define GRID_TO_EARTH_WIND_ROTATION_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define GTEW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtew check failed");

// Next-cycle implication, off while reset is low.
`define GTEW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtew check failed");

// Next-cycle implication that also holds across reset.
`define GTEW_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gtew reset check failed");

`endif

// File: design/gtew_pkg.sv
// Types and constants shared by the wind rotation block.
package gtew_pkg;

    // CORDIC datapath widths: x/y in Q16 with headroom for CORDIC gain, z in 2^-32 turns
    localparam int X_W = 44;
    localparam int Z_W = 32;

    typedef struct packed {
        logic signed [24:0] longitude;
        logic signed [23:0] latitude;
        logic signed [23:0] u_grid;
        logic signed [23:0] v_grid;
    } t_in;

    typedef struct packed {
        logic signed [23:0] u_earth;
        logic signed [23:0] v_earth;
    } t_out;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } t_vec;

    localparam int ATAN_N = 31;

    // atan(2^-i) in 2^-32 turns, rounded
    localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1
    };

endpackage

// File: design/grid_to_earth_wind_rotation_top.sv
// Top level of the grid-to-earth wind rotation block with its register port.
// Turns grid-relative winds into earth-relative winds for a conic projection, one grid
// point per request. The block takes a new request every cycle while the output is not
// stalled, and each request passes through nine front stages (offset, wrap, cone multiply,
// reciprocal divide by 360 in partial products, quadrant fold), one cell per CORDIC step,
// and the output register. Every stage has its own valid bit and fills bubbles while the
// output is stalled, so requests keep flowing until the whole chain is full. Registers:
// cone_factor at byte 0 (Q16, reset 1.0), centre_longitude at byte 4 (degrees Q16, reset 0);
// write them only while no request is in flight.
module grid_to_earth_wind_rotation_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gtew_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output gtew_pkg::t_out  o_out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int NSTEPS = (CORDIC_STEPS > gtew_pkg::ATAN_N) ? gtew_pkg::ATAN_N : CORDIC_STEPS;

    typedef enum logic {
        REG_CONE   = 1'b0,
        REG_CENTRE = 1'b1
    } t_reg_idx;

    localparam logic [16:0] CONE_RESET = 17'd65536;

    logic [16:0]        r_cone_factor;
    logic signed [24:0] r_centre_longitude;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cone_factor      <= CONE_RESET;
            r_centre_longitude <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CONE:   r_cone_factor      <= pwdata[16:0];
                REG_CENTRE: r_centre_longitude <= $signed(pwdata[24:0]);
                default:    r_cone_factor      <= r_cone_factor;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CONE:   prdata = {15'd0, r_cone_factor};
            REG_CENTRE: prdata = {7'd0, r_centre_longitude};
            default:    prdata = '0;
        endcase
    end

    gtew_pkg::t_vec w_vec [NSTEPS+1];
    logic           w_vld [NSTEPS+1];
    logic           w_rdy [NSTEPS+1];

    gtew_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_in_valid),
        .o_rdy    (o_in_ready),
        .i_data   (i_in_data),
        .i_cone   (r_cone_factor),
        .i_centre (r_centre_longitude),
        .o_vld    (w_vld[0]),
        .i_rdy    (w_rdy[0]),
        .o_vec    (w_vec[0])
    );

    for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
        gtew_cordic_cell #(
            .I (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_vec   (w_vec[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    gtew_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[NSTEPS]),
        .o_rdy   (w_rdy[NSTEPS]),
        .i_vec   (w_vec[NSTEPS]),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// File: design/gtew_front.sv
// Front pipeline: longitude offset, wrap, cone scaling, turn angle, quadrant fold, gain scaling.
module gtew_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  gtew_pkg::t_in        i_data,
    input  logic [16:0]          i_cone,
    input  logic signed [24:0]   i_centre,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output gtew_pkg::t_vec       o_vec
);
    localparam int NS = 9;
    localparam int XW = gtew_pkg::X_W;
    localparam int ZW = gtew_pkg::Z_W;

    localparam logic signed [25:0] DEG180   = 26'sd11796480;
    localparam logic signed [25:0] DEG360   = 26'sd23592960;
    localparam logic signed [54:0] GAIN_Q30 = 55'sd652032874;
    localparam logic signed [54:0] RND14    = 55'sd8192;
    localparam logic [42:0]        HALF360  = 43'd180;
    // ceil(2^46 / 45): exact floor division by 45 for 40-bit numerators
    localparam logic [40:0]        DIV45_M  = 41'd1563749870615;
    localparam logic [20:0]        M_LO     = DIV45_M[20:0];
    localparam logic [19:0]        M_HI     = DIV45_M[40:21];
    localparam logic [ZW-1:0]      EIGHTH   = 32'h2000_0000;

    logic [NS:1]   r_vld;
    logic [NS+1:1] w_en;

    always_comb begin
        w_en[NS+1] = i_rdy;
        for (int k = NS; k >= 1; k--) begin
            w_en[k] = !r_vld[k] | w_en[k+1];
        end
    end

    assign o_rdy = w_en[1];
    assign o_vld = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_vld;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: raw offset
    logic signed [25:0] r_d1;
    logic               r_s1;
    logic signed [23:0] r_u1, r_v1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_d1 <= 26'(i_data.longitude) - 26'(i_centre);
            r_s1 <= i_data.latitude[23];
            r_u1 <= i_data.u_grid;
            r_v1 <= i_data.v_grid;
        end
    end

    // stage 2: single wrap by a full circle, wind times CORDIC gain
    logic signed [25:0] n_dw2, r_dw2;
    logic               r_s2;
    logic signed [54:0] r_ux2, r_vy2;

    always_comb begin
        priority if (r_d1 > DEG180) begin
            n_dw2 = r_d1 - DEG360;
        end else if (r_d1 < -DEG180) begin
            n_dw2 = r_d1 + DEG360;
        end else begin
            n_dw2 = r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_dw2 <= n_dw2;
            r_s2  <= r_s1;
            r_ux2 <= 55'(r_u1) * GAIN_Q30;
            r_vy2 <= 55'(r_v1) * GAIN_Q30;
        end
    end

    // stage 3: cone scaling, wind rounded into Q16
    logic signed [43:0] n_p3;
    logic signed [42:0] r_p3;
    logic               r_s3;
    logic signed [XW-1:0] r_x3, r_y3;
    logic signed [54:0] n_xr3, n_yr3;

    assign n_p3  = 44'(r_dw2) * 44'($signed({1'b0, i_cone}));
    assign n_xr3 = (r_ux2 + RND14) >>> 14;
    assign n_yr3 = (r_vy2 + RND14) >>> 14;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_p3 <= n_p3[42:0];
            r_s3 <= r_s2;
            r_x3 <= XW'(n_xr3);
            r_y3 <= XW'(n_yr3);
        end
    end

    // stage 4: magnitude plus half of 360, divided by 8 (the rest of /360 is /45)
    logic [42:0] n_mag4, n_sum4;
    logic [39:0] r_n4;
    logic        r_neg4;
    logic signed [XW-1:0] r_x4, r_y4;

    assign n_mag4 = r_p3[42] ? 43'(-r_p3) : 43'(r_p3);
    assign n_sum4 = n_mag4 + HALF360;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_n4   <= n_sum4[42:3];
            r_neg4 <= r_p3[42] ^ r_s3;
            r_x4   <= r_x3;
            r_y4   <= r_y3;
        end
    end

    // stage 5: partial products of the reciprocal multiply
    logic [40:0] r_pll5, r_phl5;
    logic [39:0] r_plh5, r_phh5;
    logic        r_neg5;
    logic signed [XW-1:0] r_x5, r_y5;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_pll5 <= 41'(r_n4[19:0]) * 41'(M_LO);
            r_plh5 <= 40'(r_n4[19:0]) * 40'(M_HI);
            r_phl5 <= 41'(r_n4[39:20]) * 41'(M_LO);
            r_phh5 <= 40'(r_n4[39:20]) * 40'(M_HI);
            r_neg5 <= r_neg4;
            r_x5   <= r_x4;
            r_y5   <= r_y4;
        end
    end

    // stage 6: pairwise sums (bits above 77 never reach the 32-bit quotient)
    logic [77:0] r_sa6, r_sb6;
    logic        r_neg6;
    logic signed [XW-1:0] r_x6, r_y6;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_sa6  <= 78'(r_pll5) + (78'(r_plh5) << 21);
            r_sb6  <= (78'(r_phl5) << 20) + (78'(r_phh5) << 41);
            r_neg6 <= r_neg5;
            r_x6   <= r_x5;
            r_y6   <= r_y5;
        end
    end

    // stage 7: quotient modulo one turn
    logic [77:0] n_sum7;
    logic [ZW-1:0] r_q7;
    logic        r_neg7;
    logic signed [XW-1:0] r_x7, r_y7;

    assign n_sum7 = r_sa6 + r_sb6;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_q7   <= n_sum7[77:46];
            r_neg7 <= r_neg6;
            r_x7   <= r_x6;
            r_y7   <= r_y6;
        end
    end

    // stage 8: sign from offset and hemisphere
    logic [ZW-1:0] r_a8;
    logic signed [XW-1:0] r_x8, r_y8;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_a8 <= r_neg7 ? (-r_q7) : r_q7;
            r_x8 <= r_x7;
            r_y8 <= r_y7;
        end
    end

    // stage 9: remove nearest quarter turn, residual within +-45 degrees
    logic [ZW-1:0] n_ar9;
    logic [1:0]    n_quad9;
    gtew_pkg::t_vec n_vec9, r_vec9;

    assign n_ar9   = r_a8 + EIGHTH;
    assign n_quad9 = n_ar9[ZW-1:ZW-2];

    always_comb begin
        n_vec9.z = $signed(r_a8 - {n_quad9, {(ZW-2){1'b0}}});
        unique case (n_quad9)
            2'd0: begin
                n_vec9.x = r_x8;
                n_vec9.y = r_y8;
            end
            2'd1: begin
                n_vec9.x = r_y8;
                n_vec9.y = -r_x8;
            end
            2'd2: begin
                n_vec9.x = -r_x8;
                n_vec9.y = -r_y8;
            end
            default: begin
                n_vec9.x = -r_y8;
                n_vec9.y = r_x8;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_vec9 <= n_vec9;
        end
    end

    assign o_vec = r_vec9;

endmodule

// File: design/gtew_cordic_cell.sv
// One CORDIC rotation step with its own pipeline register.
module gtew_cordic_cell #(
    parameter int I = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  gtew_pkg::t_vec i_vec,
    output logic           o_vld,
    input  logic           i_rdy,
    output gtew_pkg::t_vec o_vec
);
    localparam int ZW = gtew_pkg::Z_W;
    localparam logic signed [ZW-1:0] ANGLE = $signed(gtew_pkg::ATAN_TURNS[I]);

    logic           r_vld;
    logic           w_en;
    gtew_pkg::t_vec n_vec, r_vec;

    assign w_en  = !r_vld | i_rdy;
    assign o_rdy = w_en;
    assign o_vld = r_vld;
    assign o_vec = r_vec;

    always_comb begin
        if (!i_vec.z[ZW-1]) begin
            n_vec.x = i_vec.x + (i_vec.y >>> I);
            n_vec.y = i_vec.y - (i_vec.x >>> I);
            n_vec.z = i_vec.z - ANGLE;
        end else begin
            n_vec.x = i_vec.x - (i_vec.y >>> I);
            n_vec.y = i_vec.y + (i_vec.x >>> I);
            n_vec.z = i_vec.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec <= n_vec;
        end
    end

endmodule

// File: design/gtew_out.sv
// Output register: rounds the CORDIC result out of Q16 and saturates to 24 bits.
module gtew_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  gtew_pkg::t_vec  i_vec,
    output logic            o_vld,
    input  logic            i_rdy,
    output gtew_pkg::t_out  o_data
);
    localparam int XW = gtew_pkg::X_W;
    localparam logic signed [XW-1:0] HALF = XW'(32768);
    localparam logic signed [XW-1:0] WMAX = XW'(8388607);
    localparam logic signed [XW-1:0] WMIN = XW'(-8388608);

    logic            r_vld;
    logic            w_en;
    gtew_pkg::t_out  n_data, r_data;
    logic signed [XW-1:0] n_ru, n_rv;

    assign w_en   = !r_vld | i_rdy;
    assign o_rdy  = w_en;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    assign n_ru = (i_vec.x + HALF) >>> 16;
    assign n_rv = (i_vec.y + HALF) >>> 16;

    always_comb begin
        priority if (n_ru > WMAX) begin
            n_data.u_earth = WMAX[23:0];
        end else if (n_ru < WMIN) begin
            n_data.u_earth = WMIN[23:0];
        end else begin
            n_data.u_earth = n_ru[23:0];
        end
        priority if (n_rv > WMAX) begin
            n_data.v_earth = WMAX[23:0];
        end else if (n_rv < WMIN) begin
            n_data.v_earth = WMIN[23:0];
        end else begin
            n_data.v_earth = n_rv[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

endmodule

// File: design/gtew_checker.sv
// Port-level checks for the wind rotation block, bound to its top level.
`include "grid_to_earth_wind_rotation_top_defines.svh"

module gtew_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input gtew_pkg::t_out o_out_data
);
    // reset empties the whole chain
    `GTEW_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid)

    // a stalled result holds its value
    `GTEW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // a free output slot lets every stage advance, so requests are taken
    `GTEW_ASSERT_NOW(a_in_ready, !o_out_valid || i_out_ready, o_in_ready)

endmodule

bind grid_to_earth_wind_rotation_top gtew_checker u_gtew_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/tb_grid_to_earth_wind_rotation_top.sv
// Self-checking testbench for the grid-to-earth wind rotation block.
module tb_grid_to_earth_wind_rotation_top;

    localparam int CORDIC_STEPS = 16;
    localparam logic [2:0] REG_CONE   = 3'd0;
    localparam logic [2:0] REG_CENTRE = 3'd4;

    localparam longint DEG        = 65536;
    localparam longint DEG180     = 180 * DEG;
    localparam longint DEG360     = 360 * DEG;
    localparam longint GAIN_Q30   = 652032874;
    localparam longint WIND_MAX   = 8388607;
    localparam longint WIND_MIN   = -8388608;
    localparam int     DRAIN_WAIT = 40;

    // atan(2^-i) in 2^-32 turns
    localparam longint ATAN_TURN [31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1, 1
    };

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    gtew_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    gtew_pkg::t_out o_out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    grid_to_earth_wind_rotation_top #(.CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

    // shadow of the block's registers
    logic        [16:0] cone_cfg = 17'd65536;
    logic signed [24:0] centre_cfg = '0;

    gtew_pkg::t_in  point_q[$];
    gtew_pkg::t_out wind_expected[$];

    int n_queued = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_clamped = 0;
    int n_settings = 1;
    int err_count = 0;
    int send_idle = 8;
    int recv_idle = 81;
    bit hold_go = 1'b0;
    bit hold_rx = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [23:0] clamp_wind(longint w);
        if (w > WIND_MAX) return WIND_MAX[23:0];
        if (w < WIND_MIN) return WIND_MIN[23:0];
        return w[23:0];
    endfunction

    function automatic gtew_pkg::t_out rotate_wind(gtew_pkg::t_in pt, logic [16:0] cone,
                                                   logic signed [24:0] centre);
        longint d, p, mag, r, x, y, z, t, xs, ys;
        logic [31:0] ang, ang_q, resid;
        logic [1:0] quad;
        gtew_pkg::t_out res;
        d = longint'(pt.longitude) - longint'(centre);
        if (d > DEG180)
            d -= DEG360;
        else if (d < -DEG180)
            d += DEG360;
        p = d * longint'(cone);
        mag = (p < 0) ? -p : p;
        r = (mag + 180) / 360;
        if (p < 0) r = -r;
        if (pt.latitude < 0) r = -r;
        ang = r[31:0];
        ang_q = ang + 32'h2000_0000;
        quad = ang_q[31:30];
        resid = ang - {quad, 30'd0};
        z = longint'($signed(resid));
        x = (longint'(pt.u_grid) * GAIN_Q30 + 8192) >>> 14;
        y = (longint'(pt.v_grid) * GAIN_Q30 + 8192) >>> 14;
        // exact quarter turns first, CORDIC only sees the residual
        for (int k = 0; k < quad; k++) begin
            t = x;
            x = y;
            y = -t;
        end
        for (int i = 0; i < ((CORDIC_STEPS > 31) ? 31 : CORDIC_STEPS); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x + ys;
                y = y - xs;
                z -= ATAN_TURN[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z += ATAN_TURN[i];
            end
        end
        res.u_earth = clamp_wind((x + 32768) >>> 16);
        res.v_earth = clamp_wind((y + 32768) >>> 16);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH %s at result %0d: got %0d expected %0d",
                     what, n_checked, got, want);
    endtask

    // request driver and receiver ready
    always @(negedge i_clk) begin
        logic          nxt_valid;
        gtew_pkg::t_in nxt_data;
        nxt_valid = i_in_valid;
        nxt_data = i_in_data;
        if (!i_in_valid || n_offered == n_accepted) begin
            nxt_valid = 1'b0;
            if (i_rst_n && point_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt_data = point_q.pop_front();
                nxt_valid = 1'b1;
                n_offered++;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt_data;
        i_out_ready <= i_rst_n && !hold_rx && ($urandom_range(99) >= recv_idle);
    end

    // result monitor; outputs checked before new requests are predicted
    always @(posedge i_clk) begin
        gtew_pkg::t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (wind_expected.size() == 0) begin
                    report_mismatch("unexpected result u_earth", o_out_data.u_earth, 0);
                end else begin
                    want = wind_expected.pop_front();
                    if (o_out_data.u_earth !== want.u_earth)
                        report_mismatch("u_earth", o_out_data.u_earth, want.u_earth);
                    if (o_out_data.v_earth !== want.v_earth)
                        report_mismatch("v_earth", o_out_data.v_earth, want.v_earth);
                    if (want.u_earth == WIND_MAX[23:0] || want.u_earth == WIND_MIN[23:0] ||
                        want.v_earth == WIND_MAX[23:0] || want.v_earth == WIND_MIN[23:0])
                        n_clamped++;
                    n_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                wind_expected.push_back(rotate_wind(i_in_data, cone_cfg, centre_cfg));
                n_accepted++;
            end
        end
    end

    // long output stall so the pipeline fills and backpressures the input
    initial begin
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d of %0d requests accepted, %0d results pending",
                 n_accepted, n_queued, wind_expected.size());
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            REG_CONE:   cone_cfg = data[16:0];
            REG_CENTRE: centre_cfg = data[24:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_point(longint lon, longint lat, longint u, longint v);
        gtew_pkg::t_in pt;
        pt.longitude = lon[24:0];
        pt.latitude = lat[23:0];
        pt.u_grid = u[23:0];
        pt.v_grid = v[23:0];
        point_q.push_back(pt);
        n_queued++;
    endtask

    function automatic longint pick_wind();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? WIND_MAX : WIND_MIN;
            1: return longint'($urandom_range(4096)) - 2048;
            default: return longint'($signed(24'($urandom())));
        endcase
    endfunction

    task automatic push_random_point();
        longint lon, lat;
        if ($urandom_range(99) < 85) begin
            lon = longint'($urandom_range(2 * DEG180)) - DEG180;
            lat = longint'($urandom_range(180 * DEG)) - 90 * DEG;
            if ($urandom_range(19) == 0) lat = 0;
        end else begin
            // whole field range, out-of-range positions included
            lon = longint'($signed(25'($urandom())));
            lat = longint'($signed(24'($urandom())));
        end
        push_point(lon, lat, pick_wind(), pick_wind());
    endtask

    task automatic drain_all();
        while (n_accepted != n_queued || wind_expected.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] cone, longint centre, int s_idle, int r_idle,
                             int count, bit long_hold);
        write_reg(REG_CONE, cone);
        write_reg(REG_CENTRE, centre[31:0]);
        n_settings++;
        send_idle = s_idle;
        recv_idle = r_idle;
        if (long_hold) hold_go = 1'b1;
        repeat (count) push_random_point();
        drain_all();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: cone 1.0, centre 0
        push_point(0, 0, 1024, -1024);
        push_point(90 * DEG, 10 * DEG, WIND_MAX, 0);
        push_point(-90 * DEG, 10 * DEG, 0, WIND_MIN);
        push_point(DEG180, DEG, 5000, 7000);
        push_point(-DEG180, -DEG, 5000, 7000);
        push_point(DEG180 + 1, 5 * DEG, -5000, 7000);
        push_point(-DEG180 - 1, -5 * DEG, 5000, -7000);
        push_point(45 * DEG, 30 * DEG, WIND_MAX, WIND_MAX);
        push_point(-45 * DEG, -30 * DEG, WIND_MIN, WIND_MIN);
        push_point(-16777216, -8388608, WIND_MIN, WIND_MAX);
        push_point(16777215, 8388607, WIND_MAX, WIND_MIN);
        push_point(12345678, 0, -1, 1);
        push_point(-7000000, -DEG, 0, 0);
        push_point(135 * DEG, 20 * DEG, 3000000, -4000000);
        push_point(1, -1, WIND_MAX, WIND_MAX);
        drain_all();

        run_phase(32'd0, -DEG180, 8, 81, 110, 1'b0);
        run_phase(32'd131071, DEG180, 8, 81, 110, 1'b0);
        run_phase(32'($urandom_range(65536)),
                  longint'($urandom_range(2 * DEG180)) - DEG180, 81, 8, 150, 1'b0);
        run_phase(32'd65536, 16777215, 81, 8, 150, 1'b0);
        run_phase(32'($urandom_range(131071)),
                  longint'($urandom_range(2 * DEG180)) - DEG180, 0, 0, 170, 1'b1);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("rotated %0d grid points under %0d register settings, %0d clamped",
                 n_checked, n_settings, n_clamped);
        $display("cone factor 0 to 131071, centre at both 180 degree ends, wrap and stall");
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
